FILE: sv/brp_pkg.sv
// Shared types and constants for the byte pattern replace unit.
`timescale 1ns / 1ps

package brp_pkg;

    // Longest replacement, and so the most output bytes one input byte can cause
    localparam int MAX_RESULTS = 8;
    localparam int JOB_BYTES_W = 8 * MAX_RESULTS;
    localparam int JOB_CNT_W   = $clog2(MAX_RESULTS + 1);

    // Entries in the job queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LEN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPL        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REPL_LEN    = 3'd4;

    // Current configuration as seen by the front end
    typedef struct packed {
        logic        enable;
        logic [63:0] pattern;
        logic [3:0]  pattern_len;
        logic [63:0] repl;
        logic [3:0]  repl_len;
    } cfg_t;

    // One unit of output work: up to eight bytes, oldest in the low byte
    typedef struct packed {
        logic [JOB_BYTES_W-1:0] bytes;
        logic [JOB_CNT_W-1:0]   count;
        logic                   from_rep;
        logic                   last;
    } job_t;

endpackage

FILE: sv/brp_front.sv
// Front end: keeps the pending window, matches it and turns the bytes it releases into output jobs.
`timescale 1ns / 1ps

module brp_front #(
    parameter int MAX_PATTERN = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    input  brp_pkg::cfg_t   cfg,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [7:0]      in_byte,
    input  logic            in_end,
    input  logic            queue_full,
    output logic            push,
    output brp_pkg::job_t   push_job
);

    localparam int FILL_W = $clog2(MAX_PATTERN + 1);

    logic [7:0]        window_reg [MAX_PATTERN];
    logic [7:0]        window_next [MAX_PATTERN];
    logic [7:0]        w_app [MAX_PATTERN];
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic [FILL_W-1:0] fill_app;
    logic [FILL_W-1:0] plen_eff;
    logic [3:0]        rlen_eff;
    logic [63:0]       win_bytes;
    logic              accept;
    logic              bypass;
    logic              at_len;
    logic              over_len;
    logic              match;
    logic              is_match;
    logic              flush_all;
    logic              drop;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;
    assign fill_app = fill_reg + 1'b1;

    // Saturate lengths to what the hardware supports
    always_comb
    begin
        if (cfg.pattern_len > 4'(MAX_PATTERN))
            plen_eff = FILL_W'(MAX_PATTERN);
        else
            plen_eff = FILL_W'(cfg.pattern_len);
        if (cfg.repl_len == 4'd0)
            rlen_eff = 4'd1;
        else if (cfg.repl_len > 4'd8)
            rlen_eff = 4'd8;
        else
            rlen_eff = cfg.repl_len;
    end

    // Append the new byte and compare the whole window in parallel
    always_comb
    begin
        match     = 1'b1;
        win_bytes = '0;
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            w_app[i] = (FILL_W'(i) == fill_reg) ? in_byte : window_reg[i];
            if (FILL_W'(i) < plen_eff && w_app[i] != cfg.pattern[8*i +: 8])
                match = 1'b0;
            win_bytes[8*i +: 8] = w_app[i];
        end
    end

    assign bypass    = !cfg.enable || plen_eff == '0;
    assign at_len    = fill_app == plen_eff;
    assign over_len  = fill_app > plen_eff;
    assign is_match  = !bypass && at_len && match;
    assign flush_all = bypass || (in_end && !is_match);
    assign drop      = !flush_all && (over_len || (at_len && !match));

    always_comb
    begin
        push_job.bytes    = is_match ? cfg.repl : win_bytes;
        push_job.from_rep = is_match;
        push_job.last     = in_end;
        if (flush_all)
            push_job.count = brp_pkg::JOB_CNT_W'(fill_app);
        else if (is_match)
            push_job.count = brp_pkg::JOB_CNT_W'(rlen_eff);
        else if (drop)
            push_job.count = brp_pkg::JOB_CNT_W'(1);
        else
            push_job.count = '0;
    end

    assign push = accept && push_job.count != '0;

    // Next window: empty, shifted by one, or just appended
    always_comb
    begin
        for (int i = 0; i < MAX_PATTERN; i++)
            window_next[i] = w_app[i];
        if (flush_all || is_match)
        begin
            fill_next = '0;
        end
        else if (drop)
        begin
            fill_next = fill_app - 1'b1;
            for (int i = 0; i < MAX_PATTERN - 1; i++)
                window_next[i] = w_app[i+1];
        end
        else
        begin
            fill_next = fill_app;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fill_reg <= '0;
        else if (accept)
            fill_reg <= fill_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            window_reg <= window_next;
    end

`ifndef NO_ASSERTIONS
    // The window never holds a full MAX_PATTERN bytes between items
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg < FILL_W'(MAX_PATTERN))
        else $error("window fill reached its capacity");
`endif

endmodule

FILE: sv/brp_queue.sv
// Small job queue between the front end and the output stage.
`timescale 1ns / 1ps

module brp_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  brp_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output logic          empty,
    output brp_pkg::job_t head
);

    localparam int DEPTH = brp_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    brp_pkg::job_t    mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full  = count_reg == CNT_W'(DEPTH);
    assign empty = count_reg == '0;
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

`ifndef NO_ASSERTIONS
    // Neither overrun nor underrun the queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full) && !(pop && empty))
        else $error("job queue overrun or underrun");
`endif

endmodule

FILE: sv/brp_back.sv
// Output stage: holds one job and sends its bytes one transfer at a time.
`timescale 1ns / 1ps

module brp_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          queue_empty,
    input  brp_pkg::job_t head,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [7:0]    out_byte,
    output logic          out_last,
    output logic          out_from_rep
);

    logic                            busy_reg;
    logic [brp_pkg::JOB_BYTES_W-1:0] bytes_reg;
    logic [brp_pkg::JOB_CNT_W-1:0]   remain_reg;
    logic                            from_rep_reg;
    logic                            last_reg;
    logic                            xfer;
    logic                            final_xfer;

    assign out_valid    = busy_reg;
    assign out_byte     = bytes_reg[7:0];
    assign out_last     = last_reg && remain_reg == brp_pkg::JOB_CNT_W'(1);
    assign out_from_rep = from_rep_reg;

    assign xfer       = busy_reg && out_ready;
    assign final_xfer = xfer && remain_reg == brp_pkg::JOB_CNT_W'(1);
    assign pop        = !queue_empty && (!busy_reg || final_xfer);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else if (pop)
            busy_reg <= 1'b1;
        else if (final_xfer)
            busy_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            bytes_reg    <= head.bytes;
            remain_reg   <= head.count;
            from_rep_reg <= head.from_rep;
            last_reg     <= head.last;
        end
        else if (xfer)
        begin
            bytes_reg  <= bytes_reg >> 8;
            remain_reg <= remain_reg - 1'b1;
        end
    end

`ifndef NO_ASSERTIONS
    // A job in progress is never cut short
    a_job_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (xfer && remain_reg > brp_pkg::JOB_CNT_W'(1)) |=> out_valid)
        else $error("output job dropped before its last byte");
`endif

endmodule

FILE: sv/byte_pattern_replace_unit.sv
// Top level of the streaming byte find-and-replace unit.
`timescale 1ns / 1ps

// Streaming find-and-replace over byte chunks. Each input transfer carries one
// byte, with tlast on the chunk's final byte. Every leftmost, non-overlapping
// occurrence of the configured pattern (1 to MAX_PATTERN bytes) is replaced by
// the configured replacement (1 to 8 bytes); tuser on the output marks bytes
// that come from the replacement, and tlast marks the final output byte of a
// chunk. A pattern length of 0, or enable cleared, passes bytes through, first
// flushing anything still held. Rate: the front end takes one input byte per
// clock whenever its two-entry job queue has room, and the window compare is
// done in that same cycle. The output stage sends one byte per clock while
// the receiver is ready, so an input byte that yields k output bytes holds
// the output until all k are sent; bytes that yield nothing (still waiting
// in the window) add no output work. With one output byte per input byte
// the unit streams one byte per clock. An input byte reaches the output
// through the queue write and then the load into the output register.
// Configuration writes are always taken at once (cfg_ready is tied high)
// and must only be made while the unit is idle.
module byte_pattern_replace_unit #(
    parameter int MAX_PATTERN = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Configuration write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [brp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                   cfg_data,
    // Input byte stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] data_byte
    input  logic                          s_tlast,   // chunk_end
    // Output byte stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,   // [7:0] out_byte
    output logic                          m_tlast,   // out_last
    output logic [0:0]                    m_tuser    // [0] from_replacement
);

    brp_pkg::cfg_t cfg_reg;
    brp_pkg::job_t push_job;
    brp_pkg::job_t head;
    logic          cfg_write;
    logic          push;
    logic          pop;
    logic          queue_full;
    logic          queue_empty;
    logic          from_rep;

    // Configuration registers; always ready to take a write
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable      <= 1'b1;
            cfg_reg.pattern     <= '0;
            cfg_reg.pattern_len <= '0;
            cfg_reg.repl        <= '0;
            cfg_reg.repl_len    <= 4'd1;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                brp_pkg::CFG_ENABLE:      cfg_reg.enable      <= cfg_data[0];
                brp_pkg::CFG_PATTERN:     cfg_reg.pattern     <= cfg_data;
                brp_pkg::CFG_PATTERN_LEN: cfg_reg.pattern_len <= cfg_data[3:0];
                brp_pkg::CFG_REPL:        cfg_reg.repl        <= cfg_data;
                brp_pkg::CFG_REPL_LEN:    cfg_reg.repl_len    <= cfg_data[3:0];
                default:                  ;  // drop writes to unknown indexes
            endcase
        end
    end

    // Front end: window, match, and job build
    brp_front #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_byte    (s_tdata),
        .in_end     (s_tlast),
        .queue_full (queue_full),
        .push       (push),
        .push_job   (push_job)
    );

    // Decouple the front end from output backpressure
    brp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (queue_full),
        .pop      (pop),
        .empty    (queue_empty),
        .head     (head)
    );

    // Output stage: one byte per transfer
    brp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .queue_empty  (queue_empty),
        .head         (head),
        .pop          (pop),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_byte     (m_tdata),
        .out_last     (m_tlast),
        .out_from_rep (from_rep)
    );

    assign m_tuser = from_rep;

`ifndef NO_ASSERTIONS
    // A chunk end always leaves output work behind it
    a_end_has_output: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> (m_tvalid || !queue_empty))
        else $error("chunk end produced no output work");
`endif

endmodule

FILE: sim/brp_rewrite_checker.sv
// Checker module: predicts the rewritten byte stream and compares the unit's output.
`timescale 1ns / 1ps

module brp_rewrite_checker #(
    parameter int MAX_PATTERN = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [brp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                   cfg_data,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] data_byte
    input  logic                          s_tlast,   // chunk_end
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [7:0]                    m_tdata,   // [7:0] out_byte
    input  logic                          m_tlast,   // out_last
    input  logic [0:0]                    m_tuser,   // [0] from_replacement
    output int                            fail_count,
    output int                            pending,
    output int                            bytes_in,
    output int                            bytes_out,
    output int                            hits
);

    localparam int REPORT_CAP = 20;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
        logic       from_rep;
    } rewrite_t;

    // Shadow copy of the rule registers
    logic        rule_enable;
    logic [63:0] rule_pattern;
    logic [3:0]  rule_pattern_len;
    logic [63:0] rule_repl;
    logic [3:0]  rule_repl_len;

    // Bytes held back because they may still start a pattern
    logic [7:0]  held_bytes [MAX_PATTERN];
    int          held_count;

    rewrite_t    rewrites_due [$];

    task automatic report_mismatch(input string msg);
        if (fail_count < REPORT_CAP)
            $display("[%0t] mismatch: %s", $time, msg);
        fail_count++;
    endtask

    function automatic void emit(input logic [7:0] value, input logic from_rep);
        rewrite_t r;
        r.value    = value;
        r.last     = 1'b0;
        r.from_rep = from_rep;
        rewrites_due.push_back(r);
    endfunction

    function automatic void drop_oldest();
        int i;
        if (held_count > 0) begin
            for (i = 0; i < MAX_PATTERN - 1; i++)
                held_bytes[i] = held_bytes[i + 1];
            held_count--;
        end
    endfunction

    function automatic void flush_held();
        int i;
        for (i = 0; i < held_count; i++)
            emit(held_bytes[i], 1'b0);
        held_count = 0;
    endfunction

    // Work out the output bytes that one input byte causes
    function automatic void predict_rewrite(input logic [7:0] in_byte, input logic chunk_end);
        int plen;
        int rlen;
        int i;
        int first_new;
        bit hit;
        plen = (rule_pattern_len > MAX_PATTERN) ? MAX_PATTERN : int'(rule_pattern_len);
        rlen = (rule_repl_len == 4'd0) ? 1 : ((rule_repl_len > 4'd8) ? 8 : int'(rule_repl_len));
        first_new = rewrites_due.size();

        held_bytes[held_count] = in_byte;
        held_count++;

        if (!rule_enable || plen == 0) begin
            flush_held();
        end else if (held_count > plen) begin
            // window outgrew a shrunk pattern: release the oldest unchecked
            emit(held_bytes[0], 1'b0);
            drop_oldest();
        end else if (held_count == plen) begin
            hit = 1'b1;
            for (i = 0; i < plen; i++)
                if (held_bytes[i] != rule_pattern[8*i +: 8])
                    hit = 1'b0;
            if (hit) begin
                for (i = 0; i < rlen; i++)
                    emit(rule_repl[8*i +: 8], 1'b1);
                held_count = 0;
                hits++;
            end else begin
                emit(held_bytes[0], 1'b0);
                drop_oldest();
            end
        end

        if (chunk_end) begin
            flush_held();
            if (rewrites_due.size() > first_new)
                rewrites_due[rewrites_due.size() - 1].last = 1'b1;
        end
    endfunction

    task automatic check_output();
        rewrite_t want;
        if (rewrites_due.size() == 0) begin
            report_mismatch($sformatf("output byte %02h with nothing expected", m_tdata));
            return;
        end
        want = rewrites_due.pop_front();
        if (m_tdata !== want.value)
            report_mismatch($sformatf("out_byte %02h, expected %02h", m_tdata, want.value));
        if (m_tlast !== want.last)
            report_mismatch($sformatf("out_last %b, expected %b", m_tlast, want.last));
        if (m_tuser[0] !== want.from_rep)
            report_mismatch($sformatf("from_replacement %b, expected %b",
                                      m_tuser[0], want.from_rep));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rule_enable      = 1'b1;
            rule_pattern     = '0;
            rule_pattern_len = '0;
            rule_repl        = '0;
            rule_repl_len    = 4'd1;
            for (int i = 0; i < MAX_PATTERN; i++)
                held_bytes[i] = 8'h00;
            held_count = 0;
            rewrites_due.delete();
            fail_count = 0;
            bytes_in   = 0;
            bytes_out  = 0;
            hits       = 0;
            pending    = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    brp_pkg::CFG_ENABLE:      rule_enable      = cfg_data[0];
                    brp_pkg::CFG_PATTERN:     rule_pattern     = cfg_data;
                    brp_pkg::CFG_PATTERN_LEN: rule_pattern_len = cfg_data[3:0];
                    brp_pkg::CFG_REPL:        rule_repl        = cfg_data;
                    brp_pkg::CFG_REPL_LEN:    rule_repl_len    = cfg_data[3:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                predict_rewrite(s_tdata, s_tlast);
                bytes_in++;
            end
            if (m_tvalid && m_tready)
            begin
                check_output();
                bytes_out++;
            end
            pending = rewrites_due.size();
        end
    end

endmodule

FILE: sim/tb.sv
// Testbench top: clock, reset, stimulus and verdict for the byte pattern replace unit.
`timescale 1ns / 1ps

module tb;

    localparam int ITEM_TARGET = 310;
    localparam int CYCLE_LIMIT = 1_000_000;
    // Input transfer to first output byte passes the queue and the output register; allow a margin
    localparam int SETTLE      = 4;
    localparam int HOLD_CYCLES = 300;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [brp_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [63:0]                   cfg_data;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [7:0]                    s_tdata;   // [7:0] data_byte
    logic                          s_tlast;   // chunk_end
    logic                          m_tvalid;
    logic                          m_tready;
    logic [7:0]                    m_tdata;   // [7:0] out_byte
    logic                          m_tlast;   // out_last
    logic [0:0]                    m_tuser;   // [0] from_replacement

    int fail_count;
    int pending;
    int bytes_in;
    int bytes_out;
    int hits;

    // Stimulus bookkeeping
    int          items_sent = 0;
    int          rule_sets  = 0;
    int          cycle_count = 0;
    logic [63:0] cur_pattern;
    int          cur_plen;
    logic        burst    = 1'b0;  // no idling on either side while set
    logic        hold_req = 1'b0;  // ask the receiver for its long hold-off

    byte_pattern_replace_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    brp_rewrite_checker rewrite_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending),
        .bytes_in   (bytes_in),
        .bytes_out  (bytes_out),
        .hits       (hits)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Stop a hung run; every correct run ends far below this
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("run stopped at the cycle limit with %0d bytes still due", pending);
            $display("TB_ERROR");
            $finish;
        end
    end

    // Idle length: mostly none or short, now and then a long one
    function automatic int pick_pause();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // Offer one byte and hold it until the transfer completes
    task automatic send_item(input logic [7:0] value, input logic chunk_end);
        int gap;
        gap = burst ? 0 : pick_pause();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tlast  <= chunk_end;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        items_sent++;
    endtask

    // Drop valid, wait for every due byte, then let the pipeline drain
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Hold cfg_valid high across a group of writes; the caller drops it
    task automatic put_reg(input logic [brp_pkg::CFG_IDX_W-1:0] idx, input logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic write_rules(input logic en, input logic [63:0] pat, input logic [3:0] plen,
                               input logic [63:0] repl, input logic [3:0] rlen);
        put_reg(brp_pkg::CFG_ENABLE,      {63'd0, en});
        put_reg(brp_pkg::CFG_PATTERN,     pat);
        put_reg(brp_pkg::CFG_PATTERN_LEN, {60'd0, plen});
        put_reg(brp_pkg::CFG_REPL,        repl);
        put_reg(brp_pkg::CFG_REPL_LEN,    {60'd0, rlen});
        cfg_valid   <= 1'b0;
        cur_pattern = pat;
        cur_plen    = (plen > 4'd8) ? 8 : int'(plen);
        rule_sets++;
    endtask

    // Build a chunk rich in whole and partial pattern copies, then send it
    task automatic send_chunk(input int len, input bit closed);
        logic [7:0] seq [$];
        int         r;
        int         k;
        while (seq.size() < len)
        begin
            r = $urandom_range(0, 99);
            if (r < 30 && cur_plen > 0)
            begin
                for (k = 0; k < cur_plen; k++)
                    seq.push_back(cur_pattern[8*k +: 8]);
            end
            else if (r < 80 && cur_plen > 0)
                seq.push_back(cur_pattern[8*$urandom_range(0, cur_plen - 1) +: 8]);
            else
                seq.push_back(8'($urandom_range(0, 255)));
        end
        for (k = 0; k < seq.size(); k++)
            send_item(seq[k], closed && (k == seq.size() - 1));
    endtask

    // Receiver: random ready runs and stalls, plus one long hold-off on request
    initial
    begin : receiver
        int  run;
        int  stall;
        bit  held_off;
        held_off = 1'b0;
        m_tready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_req && !held_off)
            begin
                held_off = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            run = $urandom_range(1, 16);
            m_tready <= 1'b1;
            repeat (run) @(posedge clk);
            stall = burst ? 0 : pick_pause();
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    initial
    begin : stimulus
        int          phase;
        int          nchunks;
        int          c;
        int          i;
        int          r;
        int          len;
        logic        en;
        logic [63:0] pat;
        logic [3:0]  plen;
        logic [63:0] repl;
        logic [3:0]  rlen;

        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tlast   <= 1'b0;
        cur_pattern = '0;
        cur_plen    = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Reset rules pass bytes straight through; try both byte extremes
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b1);

        // Two-byte pattern, upper pattern bytes set to show they are ignored;
        // hit, miss then hit, and a flush of a held byte at the chunk end
        wait_idle();
        write_rules(1'b1, 64'hFFFF_FFFF_FFFF_6261, 4'd2, 64'hFEDC_BA98_7654_3210, 4'd3);
        send_item(8'h61, 1'b0);
        send_item(8'h62, 1'b0);
        send_item(8'h61, 1'b0);
        send_item(8'h61, 1'b0);
        send_item(8'h62, 1'b0);
        send_item(8'h63, 1'b0);
        send_item(8'h61, 1'b1);

        // Full-width all-ones pattern, zero replacement length acting as one;
        // leave three bytes held with the chunk still open
        wait_idle();
        write_rules(1'b1, '1, 4'd8, 64'd0, 4'd0);
        for (i = 0; i < 11; i++)
            send_item(8'hFF, 1'b0);

        // Shrink the pattern below the held count: oldest bytes go out unchecked
        wait_idle();
        write_rules(1'b1, '1, 4'd2, 64'd0, 4'd0);
        send_item(8'hFF, 1'b0);
        send_item(8'hFF, 1'b0);

        // Disable with bytes still held: they drain ahead of the new byte
        wait_idle();
        write_rules(1'b0, '1, 4'd2, 64'd0, 4'd0);
        send_item(8'h00, 1'b1);

        // Random phases: fresh rules each time, several chunks per phase
        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            pat = '0;
            for (i = 0; i < 8; i++)
                pat[8*i +: 8] = (i > 0 && $urandom_range(0, 1) == 1) ?
                                pat[8*$urandom_range(0, i - 1) +: 8] :
                                8'($urandom_range(0, 255));
            repl = {$urandom, $urandom};
            case (phase)
                0:
                begin
                    // zero pattern, both lengths saturating from the top code
                    en = 1'b1; pat = '0; plen = 4'd15; repl = '1; rlen = 4'd15;
                end
                1:
                begin
                    // one-byte pattern with eight-byte replacement: output-bound
                    en = 1'b1; plen = 4'd1; rlen = 4'd8;
                end
                2:
                begin
                    en = 1'b1; plen = 4'd9; rlen = 4'd0;
                end
                default:
                begin
                    en = ($urandom_range(0, 9) != 0);
                    r  = $urandom_range(0, 99);
                    if (r < 10)
                        plen = 4'd0;
                    else if (r < 18)
                        plen = 4'($urandom_range(9, 15));
                    else
                        plen = 4'($urandom_range(1, 8));
                    rlen = 4'($urandom_range(0, 15));
                end
            endcase

            wait_idle();
            write_rules(en, pat, plen, repl, rlen);
            burst <= (phase == 1) || (phase % 4 == 3);
            if (phase == 1)
                hold_req <= 1'b1;

            nchunks = (phase == 1) ? 4 : $urandom_range(1, 4);
            for (c = 0; c < nchunks; c++)
            begin
                if (phase == 1)
                    len = $urandom_range(10, 30);
                else
                    len = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 12) :
                                                        $urandom_range(13, 30);
                // now and then leave the last chunk open across a rule change
                send_chunk(len, !(c == nchunks - 1 && $urandom_range(0, 3) == 0));
            end
            phase++;
        end

        // Close any chunk left open so every held byte comes out
        send_item(8'($urandom_range(0, 255)), 1'b1);
        wait_idle();
        repeat (20) @(posedge clk);

        $display("covered %0d input bytes over %0d rule settings, %0d output bytes checked",
                 bytes_in, rule_sets, bytes_out);
        $display("%0d pattern hits, incl. pass-through, saturated lengths, a long output hold-off",
                 hits);
        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
